FILE: sv/tfb_pkg.sv
// ----------------------------------------------------------------------------
// tfb_pkg
// Types and constants for the texel format to BGRA8 converter.
// ----------------------------------------------------------------------------
package tfb_pkg;

  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;
  localparam int unsigned FmtWidth     = 4;

  typedef enum logic [0:0] {
    REG_FORMAT_CODE = 1'b0
  } reg_idx_e;

  typedef enum logic [FmtWidth-1:0] {
    FMT_Y8       = 4'd0,
    FMT_AY8      = 4'd1,
    FMT_A8       = 4'd2,
    FMT_A8Y8     = 4'd3,
    FMT_R5G6B5   = 4'd4,
    FMT_A1R5G5B5 = 4'd5,
    FMT_X1R5G5B5 = 4'd6,
    FMT_A4R4G4B4 = 4'd7,
    FMT_X8R8G8B8 = 4'd8
  } fmt_e;

  typedef enum logic [1:0] {
    WID_8 = 2'd0,
    WID_6 = 2'd1,
    WID_5 = 2'd2,
    WID_4 = 2'd3
  } widen_e;

  typedef struct packed {
    logic [31:0] texel_bytes;
    logic        last_in;
  } texel_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [7:0] alpha_out;
    logic       bad_format;
    logic       last_out;
  } bgra_out_t;

  typedef struct packed {
    logic [7:0] raw;
    widen_e     kind;
  } chan_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
    chan_t alpha;
    logic  bad;
    logic  last;
  } fields_t;

endpackage

FILE: sv/tfb_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfb_cfg_regs
// APB register file holding the source format code.
// ----------------------------------------------------------------------------
module tfb_cfg_regs import tfb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  output logic [FmtWidth-1:0]     fmt_o
);

  logic [FmtWidth-1:0] fmt_q, fmt_d;
  logic                sel_fmt;

  assign sel_fmt = (reg_idx_e'(paddr[ApbAddrWidth-1]) == REG_FORMAT_CODE);
  assign pready  = 1'b1;

  always_comb begin
    fmt_d = fmt_q;
    if (psel && penable && pwrite && sel_fmt) begin
      fmt_d = pwdata[FmtWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= '0;
    end else begin
      fmt_q <= fmt_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_fmt) begin
      prdata = {{(ApbDataWidth-FmtWidth){1'b0}}, fmt_q};
    end
  end

  assign fmt_o = fmt_q;

endmodule

FILE: sv/texel_format_to_bgra8_top.sv
// ----------------------------------------------------------------------------
// texel_format_to_bgra8_top
// Packed texel to BGRA8888 converter, one texel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Each accepted texel yields one BGRA8 result through a three-stage register
// pipeline (input capture, field extraction, widening); one texel is taken
// every clock while the output keeps up, and a stall holds full stages with
// no room ahead. The format code is set over APB at address 0; the user must
// write it only while the stream is idle (unenforced). Codes 9 to 15 flag
// bad_format with zero channels. last_in travels with its texel to last_out.
// ----------------------------------------------------------------------------
module texel_format_to_bgra8_top import tfb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  texel_in_t               in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output bgra_out_t               out_data_o
);

  logic [FmtWidth-1:0] fmt;

  tfb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .fmt_o   (fmt)
  );

  function automatic logic [7:0] widen(chan_t c);
    logic [7:0] r;
    case (c.kind)
      WID_4:   r = {c.raw[3:0], c.raw[3:0]};
      WID_5:   r = {c.raw[4:0], c.raw[4:2]};
      WID_6:   r = {c.raw[5:0], c.raw[5:4]};
      default: r = c.raw;
    endcase
    return r;
  endfunction

  logic      v1_q, v2_q, v3_q;
  logic      rdy1, rdy2, rdy3;
  texel_in_t s1_q;
  fmt_e      fmt1_q;
  fields_t   s2_q, s2_d;
  bgra_out_t s3_q, s3_d;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // capture texel and format
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_q   <= in_data_i;
      fmt1_q <= fmt_e'(fmt);
    end
  end

  // extract raw fields
  always_comb begin
    logic [15:0] h;
    logic [7:0]  b0, b1, b2;
    chan_t       ones;
    h    = s1_q.texel_bytes[15:0];
    b0   = s1_q.texel_bytes[7:0];
    b1   = s1_q.texel_bytes[15:8];
    b2   = s1_q.texel_bytes[23:16];
    ones = '{raw: 8'hff, kind: WID_8};
    s2_d.blue  = '{raw: b0, kind: WID_8};
    s2_d.green = '{raw: b0, kind: WID_8};
    s2_d.red   = '{raw: b0, kind: WID_8};
    s2_d.alpha = ones;
    s2_d.bad   = 1'b0;
    s2_d.last  = s1_q.last_in;
    case (fmt1_q)
      FMT_Y8: begin
      end
      FMT_AY8: begin
        s2_d.alpha = '{raw: b0, kind: WID_8};
      end
      FMT_A8: begin
        s2_d.blue  = ones;
        s2_d.green = ones;
        s2_d.red   = ones;
        s2_d.alpha = '{raw: b0, kind: WID_8};
      end
      FMT_A8Y8: begin
        s2_d.alpha = '{raw: b1, kind: WID_8};
      end
      FMT_R5G6B5: begin
        s2_d.blue  = '{raw: {3'b0, h[4:0]},   kind: WID_5};
        s2_d.green = '{raw: {2'b0, h[10:5]},  kind: WID_6};
        s2_d.red   = '{raw: {3'b0, h[15:11]}, kind: WID_5};
      end
      FMT_A1R5G5B5, FMT_X1R5G5B5: begin
        s2_d.blue  = '{raw: {3'b0, h[4:0]},   kind: WID_5};
        s2_d.green = '{raw: {3'b0, h[9:5]},   kind: WID_5};
        s2_d.red   = '{raw: {3'b0, h[14:10]}, kind: WID_5};
        if (fmt1_q == FMT_A1R5G5B5) begin
          s2_d.alpha = '{raw: {8{h[15]}}, kind: WID_8};
        end
      end
      FMT_A4R4G4B4: begin
        s2_d.blue  = '{raw: {4'b0, h[3:0]},   kind: WID_4};
        s2_d.green = '{raw: {4'b0, h[7:4]},   kind: WID_4};
        s2_d.red   = '{raw: {4'b0, h[11:8]},  kind: WID_4};
        s2_d.alpha = '{raw: {4'b0, h[15:12]}, kind: WID_4};
      end
      FMT_X8R8G8B8: begin
        s2_d.green = '{raw: b1, kind: WID_8};
        s2_d.red   = '{raw: b2, kind: WID_8};
      end
      default: begin
        s2_d.blue  = '{raw: 8'h00, kind: WID_8};
        s2_d.green = '{raw: 8'h00, kind: WID_8};
        s2_d.red   = '{raw: 8'h00, kind: WID_8};
        s2_d.alpha = '{raw: 8'h00, kind: WID_8};
        s2_d.bad   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  // widen by bit replication
  always_comb begin
    s3_d.blue_out   = widen(s2_q.blue);
    s3_d.green_out  = widen(s2_q.green);
    s3_d.red_out    = widen(s2_q.red);
    s3_d.alpha_out  = widen(s2_q.alpha);
    s3_d.bad_format = s2_q.bad;
    s3_d.last_out   = s2_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bad_format) |->
      (out_data_o.blue_out == 8'h00 && out_data_o.green_out == 8'h00 &&
       out_data_o.red_out == 8'h00 && out_data_o.alpha_out == 8'h00))
    else $error("bad format with non-zero channels");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy3) |=> (v2_q && $stable(s2_q)))
    else $error("middle stage lost or changed a stalled item");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && !paddr[ApbAddrWidth-1]) |=>
      (fmt == $past(pwdata[FmtWidth-1:0])))
    else $error("format code write not taken");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the texel format to BGRA8 converter.
// ----------------------------------------------------------------------------
// Texels stream in over a valid/ready channel while the format code is set
// over APB between bursts. A scoreboard converts every texel on its own and
// holds the expected BGRA8 pixels in order. Each pixel that leaves the block
// is compared with the oldest one, field by field. Bursts cover every layout,
// the unsupported codes and random texels. Both sides idle at random, the
// output side holds off for a long stretch, and one burst runs with no gaps.
// ----------------------------------------------------------------------------
module testbench;
  import tfb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned             CycleLimit   = 200000;
  localparam int unsigned             BurstCount   = 27;
  localparam int unsigned             BurstLen     = 50;
  localparam int unsigned             HoldCycles   = 300;
  localparam int unsigned             SettleCycles = 6;
  localparam logic [FmtWidth-1:0]     FmtBadLow    = 4'd9;
  localparam logic [FmtWidth-1:0]     FmtBadHigh   = 4'd15;
  localparam logic [ApbAddrWidth-1:0] FmtAddr      = ApbAddrWidth'(4 * REG_FORMAT_CODE);
  localparam logic [ApbAddrWidth-1:0] UnmappedAddr =
    ApbAddrWidth'(4 * (REG_FORMAT_CODE + 1));

  class bgra_scoreboard;
    logic [FmtWidth-1:0] fmt;
    bgra_out_t           pixel_q[$];
    int unsigned         mismatches;
    int unsigned         checked;

    function new();
      fmt        = FMT_Y8;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [ApbAddrWidth-1:0] addr, logic [ApbDataWidth-1:0] data);
      if (addr == FmtAddr) begin
        fmt = data[FmtWidth-1:0];
      end
    endfunction

    function logic [7:0] rep4(logic [3:0] v);
      return {v, v};
    endfunction

    function logic [7:0] rep5(logic [4:0] v);
      return {v, v[4:2]};
    endfunction

    function logic [7:0] rep6(logic [5:0] v);
      return {v, v[5:4]};
    endfunction

    function bgra_out_t convert(texel_in_t t);
      bgra_out_t   p;
      logic [15:0] h;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      h  = t.texel_bytes[15:0];
      b0 = t.texel_bytes[7:0];
      b1 = t.texel_bytes[15:8];
      b2 = t.texel_bytes[23:16];
      p  = '0;
      p.last_out = t.last_in;
      case (fmt)
        FMT_Y8: begin
          p.blue_out = b0; p.green_out = b0; p.red_out = b0; p.alpha_out = 8'hff;
        end
        FMT_AY8: begin
          p.blue_out = b0; p.green_out = b0; p.red_out = b0; p.alpha_out = b0;
        end
        FMT_A8: begin
          p.blue_out = 8'hff; p.green_out = 8'hff; p.red_out = 8'hff; p.alpha_out = b0;
        end
        FMT_A8Y8: begin
          p.blue_out = b0; p.green_out = b0; p.red_out = b0; p.alpha_out = b1;
        end
        FMT_R5G6B5: begin
          p.blue_out  = rep5(h[4:0]);
          p.green_out = rep6(h[10:5]);
          p.red_out   = rep5(h[15:11]);
          p.alpha_out = 8'hff;
        end
        FMT_A1R5G5B5, FMT_X1R5G5B5: begin
          p.blue_out  = rep5(h[4:0]);
          p.green_out = rep5(h[9:5]);
          p.red_out   = rep5(h[14:10]);
          p.alpha_out = (fmt == FMT_X1R5G5B5 || h[15]) ? 8'hff : 8'h00;
        end
        FMT_A4R4G4B4: begin
          p.blue_out  = rep4(h[3:0]);
          p.green_out = rep4(h[7:4]);
          p.red_out   = rep4(h[11:8]);
          p.alpha_out = rep4(h[15:12]);
        end
        FMT_X8R8G8B8: begin
          p.blue_out = b0; p.green_out = b1; p.red_out = b2; p.alpha_out = 8'hff;
        end
        default: begin
          p.bad_format = 1'b1;
        end
      endcase
      return p;
    endfunction

    function void note_texel(texel_in_t t);
      pixel_q.push_back(convert(t));
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_pixel(bgra_out_t got);
      bgra_out_t want;
      if (pixel_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pixel, expected none actual %h", $time, got);
        return;
      end
      want = pixel_q.pop_front();
      checked++;
      compare_field("blue_out", want.blue_out, got.blue_out);
      compare_field("green_out", want.green_out, got.green_out);
      compare_field("red_out", want.red_out, got.red_out);
      compare_field("alpha_out", want.alpha_out, got.alpha_out);
      compare_field("bad_format", 8'(want.bad_format), 8'(got.bad_format));
      compare_field("last_out", 8'(want.last_out), 8'(got.last_out));
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;
  logic                    in_valid_i;
  logic                    in_ready_o;
  texel_in_t               in_data_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  bgra_out_t               out_data_o;

  bgra_scoreboard sb = new();
  bit             calm;
  bit             hold_req;
  int unsigned    fmt_writes;

  texel_format_to_bgra8_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("%0t: timeout with %0d pixels outstanding", $time, sb.pixel_q.size());
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_pixel(out_data_o);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  task automatic apb_transfer(input logic wr, input logic [ApbAddrWidth-1:0] addr,
                              input logic [ApbDataWidth-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      sb.write_reg(addr, data);
    end else if (prdata[FmtWidth-1:0] !== sb.fmt) begin
      sb.mismatches++;
      $display("%0t: format_code readback mismatch, expected %h actual %h",
               $time, sb.fmt, prdata[FmtWidth-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_format(input logic [FmtWidth-1:0] code);
    logic [ApbDataWidth-1:0] data;
    data = $urandom;
    data[FmtWidth-1:0] = code;
    drain();
    apb_transfer(1'b1, FmtAddr, data);
    apb_transfer(1'b0, FmtAddr, '0);
    fmt_writes++;
  endtask

  task automatic send_texel(input logic [31:0] bytes, input logic last);
    texel_in_t t;
    t.texel_bytes = bytes;
    t.last_in     = last;
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_texel(t);
  endtask

  task automatic gap();
    if (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  initial begin
    logic [FmtWidth-1:0] code;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    fmt_writes  = 0;
    rst_ni      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset layout first, then every layout at both extremes
    send_texel(32'h0000_0000, 1'b0);
    gap();
    send_texel(32'hffff_ffff, 1'b1);
    for (int c = FMT_AY8; c <= FMT_X8R8G8B8; c++) begin
      set_format(FmtWidth'(c));
      send_texel(32'h0000_0000, 1'b0);
      gap();
      send_texel(32'hffff_ffff, 1'b1);
    end
    set_format(FMT_A1R5G5B5);
    send_texel(32'h0000_8000, 1'b0);
    send_texel(32'hffff_7fff, 1'b0);
    set_format(FMT_R5G6B5);
    send_texel(32'h1234_0821, 1'b1);
    set_format(FmtBadLow);
    send_texel(32'hdead_beef, 1'b1);
    drain();
    apb_transfer(1'b1, UnmappedAddr, $urandom);
    apb_transfer(1'b0, FmtAddr, '0);
    send_texel(32'h5a5a_a5a5, 1'b0);
    set_format(FmtBadHigh);
    send_texel(32'hffff_ffff, 1'b0);

    for (int unsigned p = 0; p < BurstCount; p++) begin
      if (p == 0) begin
        code = FMT_Y8;
      end else if (p == 1) begin
        code = FmtBadHigh;
      end else if ($urandom_range(7) == 0) begin
        code = FmtWidth'($urandom_range(FmtBadLow, FmtBadHigh));
      end else begin
        code = FmtWidth'($urandom_range(FMT_X8R8G8B8));
      end
      set_format(code);
      if (p == 5) begin
        apb_transfer(1'b1, UnmappedAddr, $urandom);
        apb_transfer(1'b0, FmtAddr, '0);
      end
      calm     = (p == 3);
      hold_req = (p == 7);
      for (int unsigned i = 0; i < BurstLen; i++) begin
        send_texel($urandom, $urandom_range(7) == 0);
        if (p == 11 && i == BurstLen / 2) begin
          drain();
        end else begin
          gap();
        end
      end
      calm = 1'b0;
    end

    drain();
    $display("Checked %0d pixels over %0d format_code writes: all layouts, unsupported codes,",
             sb.checked, fmt_writes);
    $display("random texels, idle gaps, a long output hold-off and a burst with no gaps.");
    if (sb.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: texel_format_to_bgra8_top.f
sv/tfb_pkg.sv
sv/tfb_cfg_regs.sv
sv/texel_format_to_bgra8_top.sv
test/testbench.sv
